/* rtl/core/ntt8_pkg.sv */
// Shared types, constants and helpers for the radix-8 reduction-tree NTT.
// No dependencies; every other file in rtl/core uses it.
`default_nettype none

package ntt8_pkg;

   localparam int COEF_W      = 61;
   localparam int EVAL_W      = 62;
   localparam int WORD_W      = 64;
   localparam int MOD_W       = 60;
   localparam int CSR_IDX_W   = 3;
   localparam int PIPE_STAGES = 12;

   typedef logic [WORD_W-1:0] word_type;

   // Register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS      = 3'd0,
      CSR_ROOT_I       = 3'd1,
      CSR_ROOT_I_QUOT  = 3'd2,
      CSR_ROOT_J       = 3'd3,
      CSR_ROOT_J_QUOT  = 3'd4,
      CSR_ROOT_IJ      = 3'd5,
      CSR_ROOT_IJ_QUOT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] coef_0;
      logic [COEF_W-1:0] coef_1;
      logic [COEF_W-1:0] coef_2;
      logic [COEF_W-1:0] coef_3;
      logic [COEF_W-1:0] coef_4;
      logic [COEF_W-1:0] coef_5;
      logic [COEF_W-1:0] coef_6;
      logic [COEF_W-1:0] coef_7;
   } req_type;

   typedef struct packed {
      logic [EVAL_W-1:0] eval_0;
      logic [EVAL_W-1:0] eval_1;
      logic [EVAL_W-1:0] eval_2;
      logic [EVAL_W-1:0] eval_3;
      logic [EVAL_W-1:0] eval_4;
      logic [EVAL_W-1:0] eval_5;
      logic [EVAL_W-1:0] eval_6;
      logic [EVAL_W-1:0] eval_7;
   } rsp_type;

   // Subtract t once when x reaches it
   function automatic word_type fold_ge(word_type x, word_type t);
      return (x >= t) ? x - t : x;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ntt8_stream_if.sv */
// Valid/ready channel interfaces for the coefficient and result streams.
// Depends on ntt8_pkg for the payload types.
`default_nettype none

interface ntt8_req_if;
   logic             valid;
   logic             ready;
   ntt8_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ntt8_rsp_if;
   logic             valid;
   logic             ready;
   ntt8_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ntt8_shoup_mul.sv */
// Four-stage Shoup modular multiplier: r = (w*b - hi64(wq*b)*n) mod 2^64.
// Built from 32x32 partial products; depends on ntt8_pkg.
`default_nettype none

module ntt8_shoup_mul (
   input  wire logic                        clock,
   input  wire logic [3:0]                  adv,
   input  wire logic [ntt8_pkg::MOD_W-1:0]  w,
   input  wire ntt8_pkg::word_type          wq,
   input  wire logic [ntt8_pkg::MOD_W-1:0]  n,
   input  wire ntt8_pkg::word_type          b,
   output ntt8_pkg::word_type               r
);

   // Stage 1: partial products of wq*b (full) and w*b (low half only)
   ntt8_pkg::word_type q_ll_ff, q_lh_ff, q_hl_ff, q_hh_ff, wb_ll_ff;
   ntt8_pkg::word_type q_ll_in, q_lh_in, q_hl_in, q_hh_in, wb_ll_in;
   logic [31:0]        wb_lh_ff, wb_hl_ff, wb_lh_in, wb_hl_in;

   // Stage 2: quotient estimate and low product
   ntt8_pkg::word_type q_ff, wb_ff, q_in, wb_in;
   logic [33:0]        mid;

   // Stage 3: low half of q*n
   ntt8_pkg::word_type qn_ll_ff, wb3_ff, qn_ll_in;
   logic [31:0]        qn_lh_ff, qn_hl_ff, qn_lh_in, qn_hl_in;

   // Stage 4: result
   ntt8_pkg::word_type r_ff, r_in;

   always_comb begin
      q_ll_in  = 64'(wq[31:0])  * 64'(b[31:0]);
      q_lh_in  = 64'(wq[31:0])  * 64'(b[63:32]);
      q_hl_in  = 64'(wq[63:32]) * 64'(b[31:0]);
      q_hh_in  = 64'(wq[63:32]) * 64'(b[63:32]);
      wb_ll_in = 64'(w[31:0])   * 64'(b[31:0]);
      wb_lh_in = w[31:0] * b[63:32];
      wb_hl_in = 32'(w[ntt8_pkg::MOD_W-1:32]) * b[31:0];
   end

   always_comb begin
      mid   = 34'(q_ll_ff[63:32]) + 34'(q_lh_ff[31:0]) + 34'(q_hl_ff[31:0]);
      q_in  = q_hh_ff + 64'(q_lh_ff[63:32]) + 64'(q_hl_ff[63:32]) + 64'(mid[33:32]);
      wb_in = wb_ll_ff + {wb_lh_ff + wb_hl_ff, 32'b0};
   end

   always_comb begin
      qn_ll_in = 64'(q_ff[31:0]) * 64'(n[31:0]);
      qn_lh_in = q_ff[31:0] * 32'(n[ntt8_pkg::MOD_W-1:32]);
      qn_hl_in = q_ff[63:32] * n[31:0];
   end

   always_comb begin
      r_in = wb3_ff - (qn_ll_ff + {qn_lh_ff + qn_hl_ff, 32'b0});
   end

   // Advance each stage when the pipeline control lets it
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         q_ll_ff  <= q_ll_in;
         q_lh_ff  <= q_lh_in;
         q_hl_ff  <= q_hl_in;
         q_hh_ff  <= q_hh_in;
         wb_ll_ff <= wb_ll_in;
         wb_lh_ff <= wb_lh_in;
         wb_hl_ff <= wb_hl_in;
      end
      if (adv[1]) begin
         q_ff  <= q_in;
         wb_ff <= wb_in;
      end
      if (adv[2]) begin
         qn_ll_ff <= qn_ll_in;
         qn_lh_ff <= qn_lh_in;
         qn_hl_ff <= qn_hl_in;
         wb3_ff   <= wb_ff;
      end
      if (adv[3]) begin
         r_ff <= r_in;
      end
   end

   assign r = r_ff;

endmodule

`default_nettype wire

/* rtl/core/ntt8_reduction_tree_lazy.sv */
// Top level of the length-8 reduction-tree NTT with lazy reduction.
// Depends on ntt8_pkg, ntt8_req_if/ntt8_rsp_if and ntt8_shoup_mul.
//
//   channel   direction  handshake          payload
//   req_ch    in         valid/ready        coef_0..coef_7, 61 bits each
//   rsp_ch    out        valid/ready        eval_0..eval_7, 62 bits each
//   csr_*     in         csr_we             csr_index, csr_wdata (64 bits)
//
// One transfer per cycle in and out while rsp_ch is ready; the depth is set by two
// Shoup multiplies in series, four stages each, plus the add/fold stages.
// Each stage holds its own valid bit and advances when its successor frees,
// so bubbles collapse and a stalled output holds without loss.
// Reset clears the valid bits and loads the register defaults (modulus 3).
`default_nettype none

module ntt8_reduction_tree_lazy (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ntt8_req_if.sink                            req_ch,
   ntt8_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [ntt8_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire ntt8_pkg::word_type             csr_wdata
);

   localparam int NS = ntt8_pkg::PIPE_STAGES;
   localparam int MW = ntt8_pkg::MOD_W;
   localparam int EW = ntt8_pkg::EVAL_W;

   // Configuration registers
   logic [MW-1:0]      modulus_ff, root_i_ff, root_j_ff, root_ij_ff;
   ntt8_pkg::word_type root_i_quot_ff, root_j_quot_ff, root_ij_quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff      <= MW'(3);
         root_i_ff       <= '0;
         root_i_quot_ff  <= '0;
         root_j_ff       <= '0;
         root_j_quot_ff  <= '0;
         root_ij_ff      <= '0;
         root_ij_quot_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ntt8_pkg::CSR_MODULUS:      modulus_ff      <= csr_wdata[MW-1:0];
            ntt8_pkg::CSR_ROOT_I:       root_i_ff       <= csr_wdata[MW-1:0];
            ntt8_pkg::CSR_ROOT_I_QUOT:  root_i_quot_ff  <= csr_wdata;
            ntt8_pkg::CSR_ROOT_J:       root_j_ff       <= csr_wdata[MW-1:0];
            ntt8_pkg::CSR_ROOT_J_QUOT:  root_j_quot_ff  <= csr_wdata;
            ntt8_pkg::CSR_ROOT_IJ:      root_ij_ff      <= csr_wdata[MW-1:0];
            ntt8_pkg::CSR_ROOT_IJ_QUOT: root_ij_quot_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Derived multiples of the modulus
   ntt8_pkg::word_type n1, n2, n4, n8;
   assign n1 = 64'(modulus_ff);
   assign n2 = n1 << 1;
   assign n4 = n1 << 2;
   assign n8 = n1 << 3;

   // Pipeline control: stage k loads when it is empty or stage k+1 loads
   logic [NS:1]   vld_ff, vld_in;
   logic [NS+1:1] adv;

   always_comb begin
      adv[NS+1] = rsp_ch.ready;
      for (int k = NS; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = {vld_ff[NS-1:1], req_ch.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (adv[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign req_ch.ready = adv[1];
   assign rsp_ch.valid = vld_ff[NS];

   // Stage 1: fold modulo x^4-1 (sums) and x^4+1 (differences)
   ntt8_pkg::word_type a_w [4];
   ntt8_pkg::word_type b_w [4];
   ntt8_pkg::word_type s1_s_ff [4], s1_d_ff [4], s1_s_in [4], s1_d_in [4];

   always_comb begin
      a_w[0] = 64'(req_ch.data.coef_0);
      a_w[1] = 64'(req_ch.data.coef_1);
      a_w[2] = 64'(req_ch.data.coef_2);
      a_w[3] = 64'(req_ch.data.coef_3);
      b_w[0] = 64'(req_ch.data.coef_4);
      b_w[1] = 64'(req_ch.data.coef_5);
      b_w[2] = 64'(req_ch.data.coef_6);
      b_w[3] = 64'(req_ch.data.coef_7);
      for (int i = 0; i < 4; i++) begin
         s1_s_in[i] = a_w[i] + b_w[i];
         s1_d_in[i] = a_w[i] + n2 - b_w[i];
      end
   end

   // Stage 2: fold modulo x^2-1 and x^2+1; bound d0, d1
   ntt8_pkg::word_type s2_e_ff [2], s2_f_ff [2], s2_e_in [2], s2_f_in [2];
   ntt8_pkg::word_type s2_d23_ff [2];
   ntt8_pkg::word_type d01_ff [2:6][2];
   ntt8_pkg::word_type d01_in [2];

   always_comb begin
      s2_e_in[0] = s1_s_ff[0] + s1_s_ff[2];
      s2_e_in[1] = s1_s_ff[1] + s1_s_ff[3];
      s2_f_in[0] = s1_s_ff[0] + n4 - s1_s_ff[2];
      s2_f_in[1] = s1_s_ff[1] + n4 - s1_s_ff[3];
      d01_in[0]  = ntt8_pkg::fold_ge(s1_d_ff[0], n2);
      d01_in[1]  = ntt8_pkg::fold_ge(s1_d_ff[1], n2);
   end

   // Stage 3: first fold of x-1 and x+1 sums at 8n; f0 at 4n
   ntt8_pkg::word_type s3_x_ff [2], s3_x_in [2], s3_fh_ff, s3_fh_in;

   always_comb begin
      s3_x_in[0] = ntt8_pkg::fold_ge(s2_e_ff[0] + s2_e_ff[1], n8);
      s3_x_in[1] = ntt8_pkg::fold_ge(s2_e_ff[0] + n8 - s2_e_ff[1], n8);
      s3_fh_in   = ntt8_pkg::fold_ge(s2_f_ff[0], n4);
   end

   // Stage 4: finish x-1, x+1 at 4n; f0 at 2n
   logic [1:0][EW-1:0] ev01_ff [4:NS];
   logic [1:0][EW-1:0] ev01_in;
   ntt8_pkg::word_type f0q_ff [4:6];
   ntt8_pkg::word_type f0q_in, x0q, x1q;

   always_comb begin
      x0q        = ntt8_pkg::fold_ge(s3_x_ff[0], n4);
      x1q        = ntt8_pkg::fold_ge(s3_x_ff[1], n4);
      ev01_in[0] = x0q[EW-1:0];
      ev01_in[1] = x1q[EW-1:0];
      f0q_in     = ntt8_pkg::fold_ge(s3_fh_ff, n2);
   end

   // Stages 3-6: multiply f1, d2, d3 by I
   ntt8_pkg::word_type t_i, d2m, d3m;

   ntt8_shoup_mul u_mul_f1 (
      .clock (clock), .adv (adv[6:3]), .w (root_i_ff), .wq (root_i_quot_ff),
      .n (modulus_ff), .b (s2_f_ff[1]), .r (t_i)
   );

   ntt8_shoup_mul u_mul_d2 (
      .clock (clock), .adv (adv[6:3]), .w (root_i_ff), .wq (root_i_quot_ff),
      .n (modulus_ff), .b (s2_d23_ff[0]), .r (d2m)
   );

   ntt8_shoup_mul u_mul_d3 (
      .clock (clock), .adv (adv[6:3]), .w (root_i_ff), .wq (root_i_quot_ff),
      .n (modulus_ff), .b (s2_d23_ff[1]), .r (d3m)
   );

   // Stage 7: x-I, x+I outputs; fold modulo x^2-I and x^2+I
   logic [1:0][EW-1:0] ev23_ff [7:NS];
   logic [1:0][EW-1:0] ev23_in;
   ntt8_pkg::word_type s7_g_ff [4], s7_g_in [4];
   ntt8_pkg::word_type y2, y3;

   always_comb begin
      y2         = f0q_ff[6] + t_i;
      y3         = f0q_ff[6] + n2 - t_i;
      ev23_in[0] = y2[EW-1:0];
      ev23_in[1] = y3[EW-1:0];
      s7_g_in[0] = d01_ff[6][0] + d2m;
      s7_g_in[1] = d01_ff[6][1] + d3m;
      s7_g_in[2] = d01_ff[6][0] + n2 - d2m;
      s7_g_in[3] = d01_ff[6][1] + n2 - d3m;
   end

   // Stage 8: bound g0, g2; stages 8-11 multiply g1 by J, g3 by IJ
   ntt8_pkg::word_type gf_ff [8:11][2];
   ntt8_pkg::word_type gf_in [2];
   ntt8_pkg::word_type t_j, t_ij;

   always_comb begin
      gf_in[0] = ntt8_pkg::fold_ge(s7_g_ff[0], n2);
      gf_in[1] = ntt8_pkg::fold_ge(s7_g_ff[2], n2);
   end

   ntt8_shoup_mul u_mul_g1 (
      .clock (clock), .adv (adv[11:8]), .w (root_j_ff), .wq (root_j_quot_ff),
      .n (modulus_ff), .b (s7_g_ff[1]), .r (t_j)
   );

   ntt8_shoup_mul u_mul_g3 (
      .clock (clock), .adv (adv[11:8]), .w (root_ij_ff), .wq (root_ij_quot_ff),
      .n (modulus_ff), .b (s7_g_ff[3]), .r (t_ij)
   );

   // Stage 12: x-J, x+J, x-IJ, x+IJ outputs
   logic [3:0][EW-1:0] ev47_ff, ev47_in;
   ntt8_pkg::word_type y4, y5, y6, y7;

   always_comb begin
      y4         = gf_ff[11][0] + t_j;
      y5         = gf_ff[11][0] + n2 - t_j;
      y6         = gf_ff[11][1] + t_ij;
      y7         = gf_ff[11][1] + n2 - t_ij;
      ev47_in[0] = y4[EW-1:0];
      ev47_in[1] = y5[EW-1:0];
      ev47_in[2] = y6[EW-1:0];
      ev47_in[3] = y7[EW-1:0];
   end

   // Datapath registers; each stage advances with its valid bit
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_s_ff <= s1_s_in;
         s1_d_ff <= s1_d_in;
      end
      if (adv[2]) begin
         s2_e_ff      <= s2_e_in;
         s2_f_ff      <= s2_f_in;
         s2_d23_ff[0] <= s1_d_ff[2];
         s2_d23_ff[1] <= s1_d_ff[3];
         d01_ff[2]    <= d01_in;
      end
      for (int k = 3; k <= 6; k++) begin
         if (adv[k]) d01_ff[k] <= d01_ff[k-1];
      end
      if (adv[3]) begin
         s3_x_ff  <= s3_x_in;
         s3_fh_ff <= s3_fh_in;
      end
      if (adv[4]) begin
         ev01_ff[4] <= ev01_in;
         f0q_ff[4]  <= f0q_in;
      end
      for (int k = 5; k <= 6; k++) begin
         if (adv[k]) f0q_ff[k] <= f0q_ff[k-1];
      end
      for (int k = 5; k <= NS; k++) begin
         if (adv[k]) ev01_ff[k] <= ev01_ff[k-1];
      end
      if (adv[7]) begin
         ev23_ff[7] <= ev23_in;
         s7_g_ff    <= s7_g_in;
      end
      for (int k = 8; k <= NS; k++) begin
         if (adv[k]) ev23_ff[k] <= ev23_ff[k-1];
      end
      if (adv[8]) begin
         gf_ff[8] <= gf_in;
      end
      for (int k = 9; k <= 11; k++) begin
         if (adv[k]) gf_ff[k] <= gf_ff[k-1];
      end
      if (adv[NS]) begin
         ev47_ff <= ev47_in;
      end
   end

   // Drive the result payload
   always_comb begin
      rsp_ch.data.eval_0 = ev01_ff[NS][0];
      rsp_ch.data.eval_1 = ev01_ff[NS][1];
      rsp_ch.data.eval_2 = ev23_ff[NS][0];
      rsp_ch.data.eval_3 = ev23_ff[NS][1];
      rsp_ch.data.eval_4 = ev47_ff[0];
      rsp_ch.data.eval_5 = ev47_ff[1];
      rsp_ch.data.eval_6 = ev47_ff[2];
      rsp_ch.data.eval_7 = ev47_ff[3];
   end

endmodule

`default_nettype wire

/* tb/tb_ntt8_reduction_tree_lazy.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ntt8_reduction_tree_lazy: directed table, then random streams.
// Depends on ntt8_pkg and the ntt8_req_if/ntt8_rsp_if channel interfaces.

module tb_ntt8_reduction_tree_lazy;

   typedef logic [ntt8_pkg::CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [ntt8_pkg::COEF_W-1:0]    coef_type;

   localparam int                 WATCHDOG_LIMIT = 4000;
   localparam int                 RANDOM_ITEMS   = 480;
   localparam csr_idx_type        CSR_UNMAPPED   = 3'd7;
   localparam ntt8_pkg::word_type MOD_MASK       = 64'h0FFF_FFFF_FFFF_FFFF;
   localparam ntt8_pkg::word_type MOD_MAX        = 64'h0FFF_FFFF_FFFF_FFFF;
   localparam ntt8_pkg::word_type P60            = 64'd1152921504606584833;
   localparam coef_type           COEF_MAX       = '1;

   // Register settings the run moves through
   typedef enum {
      SET_RESET, SET_P17, SET_P60, SET_MAX, SET_RAW,
      SET_MIN, SET_P97, SET_P12289, SET_P30, SET_P31
   } cfg_set_type;

   typedef logic [7:0][ntt8_pkg::COEF_W-1:0] coef_vec_type;
   typedef logic [7:0][ntt8_pkg::EVAL_W-1:0] eval_vec_type;

   typedef struct {
      cfg_set_type       cfg_sel;
      ntt8_pkg::req_type item;
      bit                typed;
      ntt8_pkg::rsp_type want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   csr_idx_type        csr_index;
   ntt8_pkg::word_type csr_wdata;

   ntt8_req_if req_ch ();
   ntt8_rsp_if rsp_ch ();

   ntt8_pkg::word_type csr_shadow [8];
   ntt8_pkg::rsp_type  pending_evals [$];
   stim_row_type       stim_table [$];
   int                 mismatches = 0;
   bit                 in_calm = 1'b0;

   ntt8_reduction_tree_lazy dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic ntt8_pkg::word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic ntt8_pkg::word_type cond_sub(ntt8_pkg::word_type x,
                                                   ntt8_pkg::word_type t);
      return (x >= t) ? x - t : x;
   endfunction

   // Shoup product w*b with quotient wq, wrapping at 64 bits
   function automatic ntt8_pkg::word_type mul_by_root(ntt8_pkg::word_type w,
                                                      ntt8_pkg::word_type wq,
                                                      ntt8_pkg::word_type b,
                                                      ntt8_pkg::word_type n);
      logic [127:0] prod;
      prod = {64'd0, wq} * {64'd0, b};
      return w * b - prod[127:64] * n;
   endfunction

   function automatic ntt8_pkg::word_type mul_mod(ntt8_pkg::word_type a,
                                                  ntt8_pkg::word_type b,
                                                  ntt8_pkg::word_type n);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod % {64'd0, n};
      return prod[63:0];
   endfunction

   function automatic ntt8_pkg::word_type pow_mod(ntt8_pkg::word_type base,
                                                  ntt8_pkg::word_type e,
                                                  ntt8_pkg::word_type n);
      ntt8_pkg::word_type acc;
      acc = 1;
      base = base % n;
      while (e != 0) begin
         if (e[0]) begin
            acc = mul_mod(acc, base, n);
         end
         base = mul_mod(base, base, n);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic ntt8_pkg::word_type shoup_quotient(ntt8_pkg::word_type w,
                                                         ntt8_pkg::word_type n);
      logic [127:0] num;
      num = {w, 64'd0} / {64'd0, n};
      return num[63:0];
   endfunction

   // Expected evaluations of one transfer under the current register copy
   function automatic ntt8_pkg::rsp_type ntt8_evaluate(ntt8_pkg::req_type item);
      coef_vec_type       c;
      eval_vec_type       ev;
      ntt8_pkg::word_type n, n2, n4, n8, t, e0, e1, f0, f1, g0, g1, g2, g3;
      ntt8_pkg::word_type s [4];
      ntt8_pkg::word_type d [4];
      ntt8_pkg::word_type res [8];
      int                 k;
      c = item;
      n = csr_shadow[ntt8_pkg::CSR_MODULUS];
      n2 = n << 1;
      n4 = n << 2;
      n8 = n << 3;
      // fold modulo x^4-1 and x^4+1; c[7-k] is coef_k
      for (k = 0; k < 4; k++) begin
         s[k] = c[7-k] + c[3-k];
         d[k] = c[7-k] + n2 - c[3-k];
      end
      e0 = s[0] + s[2];
      e1 = s[1] + s[3];
      f0 = s[0] + n4 - s[2];
      f1 = s[1] + n4 - s[3];
      res[0] = cond_sub(cond_sub(e0 + e1, n8), n4);
      res[1] = cond_sub(cond_sub(e0 + n8 - e1, n8), n4);
      // x-I and x+I
      t = mul_by_root(csr_shadow[ntt8_pkg::CSR_ROOT_I], csr_shadow[ntt8_pkg::CSR_ROOT_I_QUOT],
                      f1, n);
      f0 = cond_sub(cond_sub(f0, n4), n2);
      res[2] = f0 + t;
      res[3] = f0 + n2 - t;
      // x^2-I and x^2+I
      d[2] = mul_by_root(csr_shadow[ntt8_pkg::CSR_ROOT_I],
                         csr_shadow[ntt8_pkg::CSR_ROOT_I_QUOT], d[2], n);
      d[3] = mul_by_root(csr_shadow[ntt8_pkg::CSR_ROOT_I],
                         csr_shadow[ntt8_pkg::CSR_ROOT_I_QUOT], d[3], n);
      d[0] = cond_sub(d[0], n2);
      d[1] = cond_sub(d[1], n2);
      g0 = d[0] + d[2];
      g1 = d[1] + d[3];
      g2 = d[0] + n2 - d[2];
      g3 = d[1] + n2 - d[3];
      // x-J, x+J, x-IJ, x+IJ
      t = mul_by_root(csr_shadow[ntt8_pkg::CSR_ROOT_J], csr_shadow[ntt8_pkg::CSR_ROOT_J_QUOT],
                      g1, n);
      g0 = cond_sub(g0, n2);
      res[4] = g0 + t;
      res[5] = g0 + n2 - t;
      t = mul_by_root(csr_shadow[ntt8_pkg::CSR_ROOT_IJ],
                      csr_shadow[ntt8_pkg::CSR_ROOT_IJ_QUOT], g3, n);
      g2 = cond_sub(g2, n2);
      res[6] = g2 + t;
      res[7] = g2 + n2 - t;
      for (k = 0; k < 8; k++) begin
         ev[7-k] = res[k][ntt8_pkg::EVAL_W-1:0];
      end
      return ev;
   endfunction

   // Idle length: mostly short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 16);
      end
      return $urandom_range(40, 150);
   endfunction

   // Coefficient mostly below 2n, with edge values and some out-of-range noise
   function automatic coef_type pick_coef();
      ntt8_pkg::word_type n, two_n;
      int                 r;
      n = csr_shadow[ntt8_pkg::CSR_MODULUS];
      two_n = n << 1;
      r = $urandom_range(0, 99);
      if (two_n == 0 || r >= 88) begin
         return coef_type'(rand_word());
      end
      if (r < 10) begin
         case (r % 4)
            0: return '0;
            1: return coef_type'(two_n - 64'd1);
            2: return coef_type'(n - 64'd1);
            default: return coef_type'(n);
         endcase
      end
      return coef_type'(rand_word() % two_n);
   endfunction

   function automatic ntt8_pkg::req_type coefs8(input coef_type c0, c1, c2, c3,
                                                c4, c5, c6, c7);
      return {c0, c1, c2, c3, c4, c5, c6, c7};
   endfunction

   function automatic ntt8_pkg::req_type same8(input coef_type v);
      return {8{v}};
   endfunction

   task automatic add_row(cfg_set_type cfg_sel, ntt8_pkg::req_type item, bit typed,
                          ntt8_pkg::rsp_type want);
      stim_row_type row;
      row.cfg_sel = cfg_sel;
      row.item = item;
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endtask

   // One register write; the shadow copy follows the same masking
   task automatic csr_write(input csr_idx_type idx, input ntt8_pkg::word_type value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         ntt8_pkg::CSR_MODULUS, ntt8_pkg::CSR_ROOT_I, ntt8_pkg::CSR_ROOT_J,
         ntt8_pkg::CSR_ROOT_IJ: csr_shadow[idx] = value & MOD_MASK;
         ntt8_pkg::CSR_ROOT_I_QUOT, ntt8_pkg::CSR_ROOT_J_QUOT,
         ntt8_pkg::CSR_ROOT_IJ_QUOT: csr_shadow[idx] = value;
         default: ;
      endcase
   endtask

   // Load a modulus with its roots and Shoup quotients, or raw words for the bad set
   task automatic program_set(input cfg_set_type sel);
      ntt8_pkg::word_type n, j, i_root, ij_root;
      int                 g, r;
      bit                 found;
      case (sel)
         SET_P17:    n = 17;
         SET_P60:    n = P60;
         SET_MAX:    n = MOD_MAX;
         SET_MIN:    n = 3;
         SET_P97:    n = 97;
         SET_P12289: n = 12289;
         SET_P30:    n = 998244353;
         SET_P31:    n = 2013265921;
         default:    n = 0;
      endcase
      if (sel == SET_RAW || n == 0) begin
         for (r = int'(ntt8_pkg::CSR_MODULUS); r <= int'(ntt8_pkg::CSR_ROOT_IJ_QUOT); r++) begin
            csr_write(csr_idx_type'(r), rand_word());
         end
      end else begin
         // search for a primitive eighth root; fall back to a random residue
         found = 1'b0;
         j = 0;
         for (g = 2; g < 64 && !found; g++) begin
            j = pow_mod(g, (n - 1) >> 3, n);
            found = (pow_mod(j, 4, n) == n - 1);
         end
         if (!found) begin
            j = rand_word() % n;
         end
         i_root = mul_mod(j, j, n);
         ij_root = mul_mod(i_root, j, n);
         csr_write(ntt8_pkg::CSR_MODULUS, n);
         csr_write(ntt8_pkg::CSR_ROOT_I, i_root);
         csr_write(ntt8_pkg::CSR_ROOT_I_QUOT, shoup_quotient(i_root, n));
         csr_write(ntt8_pkg::CSR_ROOT_J, j);
         csr_write(ntt8_pkg::CSR_ROOT_J_QUOT, shoup_quotient(j, n));
         csr_write(ntt8_pkg::CSR_ROOT_IJ, ij_root);
         csr_write(ntt8_pkg::CSR_ROOT_IJ_QUOT, shoup_quotient(ij_root, n));
      end
      csr_write(CSR_UNMAPPED, rand_word());
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drive one coefficient block and record its expected evaluations on transfer
   task automatic send_item(input ntt8_pkg::req_type item, input bit typed,
                            input ntt8_pkg::rsp_type want);
      int gap;
      gap = (!in_calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= item;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      pending_evals.push_back(typed ? want : ntt8_evaluate(item));
   endtask

   // Hold off input until every expected evaluation has arrived
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_evals.size() != 0) @(posedge clock);
   endtask

   // Result side: random back-pressure and in-order field checks
   initial begin
      int           stall_left, mode_left, k;
      bit           calm;
      eval_vec_type got, want;
      rsp_ch.ready = 1'b0;
      stall_left = 0;
      mode_left = 0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_evals.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result %h", $time, rsp_ch.data);
            end else begin
               want = pending_evals.pop_front();
               got = rsp_ch.data;
               for (k = 0; k < 8; k++) begin
                  if (got[7-k] !== want[7-k]) begin
                     mismatches++;
                     $display("%0t: eval_%0d expected %h, got %h",
                              $time, k, want[7-k], got[7-k]);
                  end
               end
            end
         end
         if (mode_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) begin
               stall_left = gap_len();
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus: directed table, then random phases under changing settings
   initial begin
      cfg_set_type  cur, sel;
      coef_vec_type v;
      int           sent, len, k, i;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      for (k = 0; k < 8; k++) begin
         csr_shadow[k] = 0;
      end
      csr_shadow[ntt8_pkg::CSR_MODULUS] = 3;

      // defaults after reset: modulus 3, all roots zero
      add_row(SET_RESET, same8(0), 1'b1,
              {62'd0, 62'd0, 62'd0, 62'd6, 62'd0, 62'd6, 62'd0, 62'd6});
      add_row(SET_RESET, same8(5), 1'b1,
              {62'd4, 62'd0, 62'd0, 62'd6, 62'd0, 62'd6, 62'd0, 62'd6});
      add_row(SET_RESET, same8(COEF_MAX), 1'b0, '0);
      add_row(SET_RESET, coefs8(0, COEF_MAX, 0, COEF_MAX, COEF_MAX, 0, COEF_MAX, 0), 1'b0, '0);
      // small prime: impulses and edge values
      add_row(SET_P17, same8(0), 1'b0, '0);
      add_row(SET_P17, same8(33), 1'b0, '0);
      add_row(SET_P17, coefs8(1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(SET_P17, coefs8(0, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(SET_P17, coefs8(0, 0, 0, 1, 0, 0, 0, 0), 1'b0, '0);
      add_row(SET_P17, coefs8(0, 0, 0, 0, 1, 0, 0, 0), 1'b0, '0);
      add_row(SET_P17, coefs8(0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0);
      add_row(SET_P17, coefs8(0, 0, 0, 0, 0, 0, 0, 33), 1'b0, '0);
      add_row(SET_P17, coefs8(33, 0, 16, 17, 1, 32, 5, 9), 1'b0, '0);
      // 60-bit prime
      add_row(SET_P60, same8(0), 1'b0, '0);
      add_row(SET_P60, same8(coef_type'(P60 * 2 - 1)), 1'b0, '0);
      add_row(SET_P60, same8(COEF_MAX), 1'b0, '0);
      add_row(SET_P60, coefs8(0, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(SET_P60, coefs8(coef_type'(P60 - 1), coef_type'(P60), coef_type'(P60 * 2 - 1),
                              0, 1, coef_type'(P60 + 1), 2, coef_type'(P60 * 2 - 2)),
              1'b0, '0);
      // largest modulus the register holds
      add_row(SET_MAX, same8(0), 1'b0, '0);
      add_row(SET_MAX, same8(coef_type'(MOD_MAX * 2 - 1)), 1'b0, '0);
      add_row(SET_MAX, coefs8(coef_type'(MOD_MAX * 2 - 1), 0, coef_type'(MOD_MAX * 2 - 1), 0,
                              0, coef_type'(MOD_MAX * 2 - 1), 0,
                              coef_type'(MOD_MAX * 2 - 1)), 1'b0, '0);
      // raw register words, no consistency between modulus and quotients
      add_row(SET_RAW, same8(61'h0AAA_AAAA_AAAA_AAAA), 1'b0, '0);
      add_row(SET_RAW, coefs8(61'h1555_5555_5555_5555, 0, COEF_MAX, 61'h0AAA_AAAA_AAAA_AAAA,
                              1, 61'h1000_0000_0000_0000, 7, COEF_MAX), 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table, reprogramming when the setting changes
      cur = SET_RESET;
      for (i = 0; i < stim_table.size(); i++) begin
         if (stim_table[i].cfg_sel != cur) begin
            drain_results();
            program_set(stim_table[i].cfg_sel);
            cur = stim_table[i].cfg_sel;
         end
         send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
      end

      // random phases, each under a fresh setting
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         sel = cfg_set_type'($urandom_range(int'(SET_P17), int'(SET_P31)));
         drain_results();
         program_set(sel);
         in_calm = ($urandom_range(0, 3) == 0);
         len = $urandom_range(30, 90);
         if (len > RANDOM_ITEMS - sent) begin
            len = RANDOM_ITEMS - sent;
         end
         repeat (len) begin
            for (k = 0; k < 8; k++) begin
               v[k] = pick_coef();
            end
            send_item(v, 1'b0, '0);
            sent++;
         end
      end

      drain_results();
      repeat (ntt8_pkg::PIPE_STAGES + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* ntt8_reduction_tree_lazy.f */
rtl/core/ntt8_pkg.sv
rtl/core/ntt8_stream_if.sv
rtl/core/ntt8_shoup_mul.sv
rtl/core/ntt8_reduction_tree_lazy.sv
tb/tb_ntt8_reduction_tree_lazy.sv
